// File: hdl/kcvt_pkg.sv
package kcvt_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam logic [31:0] Q_POS_RST  = 32'd3277;
   localparam logic [31:0] Q_VEL_RST  = 32'd328;
   localparam logic [31:0] R_MEAS_RST = 32'd131072;

   localparam logic [1:0] REG_Q_POS  = 2'd0;
   localparam logic [1:0] REG_Q_VEL  = 2'd1;
   localparam logic [1:0] REG_R_MEAS = 2'd2;

   localparam logic [63:0] GAP_LIMIT_US   = 64'd500000;
   localparam logic [63:0] GAP_DEFAULT_US = 64'd1000;
   localparam logic [19:0] US_PER_SEC     = 20'd1000000;

   // shared unit operations
   localparam logic [2:0] OP_MUL = 3'd0;
   localparam logic [2:0] OP_ADD = 3'd1;
   localparam logic [2:0] OP_SUB = 3'd2;

   // saturate a 64-bit signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) r = 32'sh7fffffff;
      else if (x < -64'sd2147483648) r = 32'sh80000000;
      else r = x[31:0];
      return r;
   endfunction

endpackage

// File: hdl/kcvt_alu.sv
// Shared arithmetic unit: saturating add, subtract, fixed-point multiply.
// One operation per cycle, registered result.
module kcvt_alu #(
   parameter int FRAC_BITS = kcvt_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic [2:0]         op,
   input  logic signed [32:0] a,
   input  logic signed [32:0] b,
   output logic signed [31:0] y
);

   logic signed [65:0] prod;
   logic signed [65:0] rnd;
   logic signed [65:0] sum;
   logic signed [31:0] y_in;
   logic signed [31:0] y_ff;

   always_comb begin
      prod = 66'(a) * 66'(b);
      rnd  = (prod + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      sum  = 66'(a) + 66'(b);
      case (op)
         kcvt_pkg::OP_MUL: y_in = kcvt_pkg::sat32(rnd[63:0]);
         kcvt_pkg::OP_SUB: y_in = kcvt_pkg::sat32(64'(a) - 64'(b));
         default:          y_in = kcvt_pkg::sat32(sum[63:0]);
      endcase
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in;
   end

   assign y = y_ff;

endmodule

// File: hdl/kcvt_div.sv
// Restoring divider: sat32((a << FRAC_BITS) / b), truncated toward zero,
// one quotient bit per cycle, zero divisor gives zero.
module kcvt_div #(
   parameter int FRAC_BITS = kcvt_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   output logic               done,
   output logic signed [31:0] q
);

   localparam int NW = 32 + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] num_ff, num_in;
   logic [31:0]   den_ff, den_in;
   logic [32:0]   rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          neg_ff, neg_in;
   logic          zero_ff, zero_in;
   logic          done_ff, done_in;
   logic [33:0]   trial;
   logic [32:0]   shifted;
   logic signed [63:0] sq;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      shifted = {rem_ff[31:0], num_ff[NW-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      // load magnitudes
      if (start) begin
         num_in  = NW'(a[31] ? 33'(-34'(a)) : 33'(a)) << FRAC_BITS;
         den_in  = b[31] ? 32'(-33'(b)) : 32'(b);
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
         neg_in  = a[31] ^ b[31];
         zero_in = (b == 32'sd0);
      end else if (busy_ff) begin
         // one quotient bit
         num_in = num_ff << 1;
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      sq = neg_ff ? -64'(quo_ff) : 64'(quo_ff);
      q  = zero_ff ? 32'sd0 : kcvt_pkg::sat32(sq);
   end

   assign done = done_ff;

endmodule

// File: hdl/kalman_const_velocity_tracker_core.sv
// Two-state constant-velocity Kalman tracker, one shared ALU under a sequencer.
// Flow: a first update returns the measured position, a reset item returns no word,
// and a later update (Q16.16 at the default FRAC_BITS) finds dt by reciprocal multiply,
// runs 26 ALU steps of issue and write plus two gain divisions, then commits.
// Throughput: one item at a time; req_tready is low while an item is in work
// and while a result word waits. Reset: synchronous; restores sequencer, track state and CSR defaults.
module kalman_const_velocity_tracker_core #(
   parameter int FRAC_BITS = kcvt_pkg::FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // measured_pos[31:0], time_us[95:32]
   input  logic         req_tuser,   // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // filtered_pos[31:0]
   input  logic         csr_wen,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DT   = 3'd1;
   localparam logic [2:0] ST_MATH = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   // dt = floor((gap * 2^(F-6) + 7812) / 15625), same as round half up of
   // gap * 2^F / 1e6; the division is a multiply by ceil(2^51 / 15625)
   localparam int          DT_SHIFT = FRAC_BITS - 6;
   localparam int          DT_POST  = 51;
   localparam logic [37:0] DT_RECIP = 38'd144115188076;
   localparam logic [37:0] DT_HALF  = 38'd7812;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic [31:0] q_pos_ff, q_vel_ff, r_meas_ff;
   logic signed [31:0] pos_ff, vel_ff, cpp_ff, cpv_ff, cvp_ff, cvv_ff;
   logic [63:0] prev_ff;
   logic        primed_ff;
   logic signed [31:0] meas_ff;
   logic [31:0] out_ff;
   logic        ovalid_ff;
   // scratch registers t[0..15]
   logic signed [31:0] t_ff [16];

   // dt unit state: clamped gap, step count, product accumulator
   logic [18:0] dgap_ff;
   logic [1:0]  dcnt_ff;
   logic [75:0] dacc_ff;
   logic [63:0] gap;
   logic [37:0] dnum;
   logic [18:0] dmul_b;
   logic [56:0] dprod;

   logic [2:0]  alu_op;
   logic signed [32:0] alu_a, alu_b;
   logic signed [31:0] alu_y;
   logic [3:0]  wr_idx;
   logic        wr_en;
   logic        div_start, div_done;
   logic signed [31:0] div_a, div_b, div_q;

   kcvt_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
      .clock(clock), .op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y));

   kcvt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .a(div_a), .b(div_b),
      .done(div_done), .q(div_q));

   function automatic logic signed [32:0] sx(input logic signed [31:0] v);
      return 33'(v);
   endfunction
   function automatic logic signed [32:0] zx(input logic [31:0] v);
      return {1'b0, v};
   endfunction

   assign req_tready = (state_ff == ST_IDLE) && !ovalid_ff;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = out_ff;

   // a zero gap or one over 500000 becomes 1000, so it fits 19 bits; then one
   // partial product of the reciprocal per cycle, low half first
   always_comb begin
      gap = req_tdata[95:32] - prev_ff;
      if (gap == 64'd0 || gap > kcvt_pkg::GAP_LIMIT_US) gap = kcvt_pkg::GAP_DEFAULT_US;
      dnum   = (38'(dgap_ff) << DT_SHIFT) + DT_HALF;
      dmul_b = (dcnt_ff == 2'd2) ? DT_RECIP[18:0] : DT_RECIP[37:19];
      dprod  = 57'(dnum) * 57'(dmul_b);
   end

   // microprogram: step -> ALU op, operands, destination
   // t0 dt, t1 p_pred, t2 p00, t3 p01, t4 p10, t5 p11, t6 y, t7 s,
   // t8 k0, t9 k1, t10..t15 temps and new state (t8, t9 are reused)
   always_comb begin
      alu_op = kcvt_pkg::OP_ADD;
      alu_a  = '0;
      alu_b  = '0;
      wr_idx = 4'd10;
      unique case (step_ff)
         5'd0:  begin alu_op = kcvt_pkg::OP_MUL; alu_a = sx(vel_ff);  alu_b = sx(t_ff[0]);  wr_idx = 4'd10; end
         5'd1:  begin alu_a = sx(pos_ff);  alu_b = sx(t_ff[10]); wr_idx = 4'd1;  end
         5'd2:  begin alu_a = sx(cvp_ff);  alu_b = sx(cpv_ff);   wr_idx = 4'd10; end
         5'd3:  begin alu_op = kcvt_pkg::OP_MUL; alu_a = sx(t_ff[0]); alu_b = sx(t_ff[10]); wr_idx = 4'd10; end
         5'd4:  begin alu_a = sx(cpp_ff);  alu_b = sx(t_ff[10]); wr_idx = 4'd2;  end
         5'd5:  begin alu_op = kcvt_pkg::OP_MUL; alu_a = sx(t_ff[0]); alu_b = sx(t_ff[0]); wr_idx = 4'd10; end
         5'd6:  begin alu_op = kcvt_pkg::OP_MUL; alu_a = sx(t_ff[10]); alu_b = sx(cvv_ff); wr_idx = 4'd10; end
         5'd7:  begin alu_a = sx(t_ff[2]); alu_b = sx(t_ff[10]); wr_idx = 4'd2; end
         5'd8:  begin alu_a = sx(t_ff[2]); alu_b = zx(q_pos_ff); wr_idx = 4'd2; end
         5'd9:  begin alu_op = kcvt_pkg::OP_MUL; alu_a = sx(t_ff[0]); alu_b = sx(cvv_ff); wr_idx = 4'd11; end
         5'd10: begin alu_a = sx(cpv_ff); alu_b = sx(t_ff[11]); wr_idx = 4'd3; end
         5'd11: begin alu_a = sx(cvp_ff); alu_b = sx(t_ff[11]); wr_idx = 4'd4; end
         5'd12: begin alu_a = sx(cvv_ff); alu_b = zx(q_vel_ff); wr_idx = 4'd5; end
         5'd13: begin alu_op = kcvt_pkg::OP_SUB; alu_a = sx(meas_ff); alu_b = sx(t_ff[1]); wr_idx = 4'd6; end
         5'd14: begin alu_a = sx(t_ff[2]); alu_b = zx(r_meas_ff); wr_idx = 4'd7; end
         // 15, 16: divisions (k0, k1) handled in ST_DIV
         5'd17: begin alu_op = kcvt_pkg::OP_MUL; alu_a = sx(t_ff[8]); alu_b = sx(t_ff[6]); wr_idx = 4'd10; end
         5'd18: begin alu_a = sx(t_ff[1]); alu_b = sx(t_ff[10]); wr_idx = 4'd12; end
         5'd19: begin alu_op = kcvt_pkg::OP_MUL; alu_a = sx(t_ff[9]); alu_b = sx(t_ff[6]); wr_idx = 4'd10; end
         5'd20: begin alu_a = sx(vel_ff); alu_b = sx(t_ff[10]); wr_idx = 4'd13; end
         5'd21: begin alu_op = kcvt_pkg::OP_SUB; alu_a = zx(ONE); alu_b = sx(t_ff[8]); wr_idx = 4'd14; end
         5'd22: begin alu_op = kcvt_pkg::OP_MUL; alu_a = sx(t_ff[14]); alu_b = sx(t_ff[2]); wr_idx = 4'd15; end
         5'd23: begin alu_op = kcvt_pkg::OP_MUL; alu_a = sx(t_ff[14]); alu_b = sx(t_ff[3]); wr_idx = 4'd11; end
         5'd24: begin alu_op = kcvt_pkg::OP_MUL; alu_a = sx(t_ff[9]); alu_b = sx(t_ff[2]); wr_idx = 4'd10; end
         5'd25: begin alu_op = kcvt_pkg::OP_SUB; alu_a = sx(t_ff[4]); alu_b = sx(t_ff[10]); wr_idx = 4'd8; end
         5'd26: begin alu_op = kcvt_pkg::OP_MUL; alu_a = sx(t_ff[9]); alu_b = sx(t_ff[3]); wr_idx = 4'd10; end
         5'd27: begin alu_op = kcvt_pkg::OP_SUB; alu_a = sx(t_ff[5]); alu_b = sx(t_ff[10]); wr_idx = 4'd9; end
         default: begin alu_a = '0; alu_b = '0; wr_idx = 4'd10; end
      endcase
   end

   // ALU result lands in the next cycle; each step has an issue phase and a write phase
   logic phase_ff;
   assign wr_en = (state_ff == ST_MATH) && phase_ff;

   assign div_start = (state_ff == ST_MATH) && !phase_ff && (step_ff == 5'd15 || step_ff == 5'd16);
   assign div_a = (step_ff == 5'd15) ? t_ff[2] : t_ff[4];
   assign div_b = t_ff[7];

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid && req_tready && !req_tuser && primed_ff) begin
            state_in = ST_DT;
         end
         ST_DT: if (dcnt_ff == 2'd0) begin
            state_in = ST_MATH;
            step_in  = 5'd0;
         end
         ST_MATH: begin
            if (!phase_ff && (step_ff == 5'd15 || step_ff == 5'd16)) begin
               state_in = ST_DIV;
            end else if (phase_ff) begin
               if (step_ff == 5'd27) state_in = ST_OUT;
               else step_in = step_ff + 5'd1;
            end
         end
         ST_DIV: if (div_done) begin
            state_in = ST_MATH;
            step_in  = step_ff + 5'd1;
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= '0;
         phase_ff  <= 1'b0;
         ovalid_ff <= 1'b0;
         primed_ff <= 1'b0;
         prev_ff   <= '0;
         q_pos_ff  <= kcvt_pkg::Q_POS_RST;
         q_vel_ff  <= kcvt_pkg::Q_VEL_RST;
         r_meas_ff <= kcvt_pkg::R_MEAS_RST;
         pos_ff    <= '0;
         vel_ff    <= '0;
         cpp_ff    <= ONE;
         cpv_ff    <= '0;
         cvp_ff    <= '0;
         cvv_ff    <= ONE;
         dcnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         phase_ff <= (state_ff == ST_MATH) && (state_in == ST_MATH) && !phase_ff
                     && !(step_ff == 5'd15 || step_ff == 5'd16);
         if (rsp_tvalid && rsp_tready) ovalid_ff <= 1'b0;
         // register writes
         if (csr_wen) begin
            unique case (csr_index)
               kcvt_pkg::REG_Q_POS:  q_pos_ff  <= csr_wdata;
               kcvt_pkg::REG_Q_VEL:  q_vel_ff  <= csr_wdata;
               kcvt_pkg::REG_R_MEAS: r_meas_ff <= csr_wdata;
               default: ;
            endcase
         end
         // accept a word
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               pos_ff <= '0; vel_ff <= '0; cpp_ff <= ONE; cpv_ff <= '0;
               cvp_ff <= '0; cvv_ff <= ONE; primed_ff <= 1'b0;
            end else if (!primed_ff) begin
               pos_ff    <= req_tdata[31:0];
               vel_ff    <= '0;
               prev_ff   <= req_tdata[95:32];
               primed_ff <= 1'b1;
               ovalid_ff <= 1'b1;
            end else begin
               prev_ff <= req_tdata[95:32];
               dcnt_ff <= 2'd2;
            end
         end else if (state_ff == ST_DT && dcnt_ff != 2'd0) begin
            dcnt_ff <= dcnt_ff - 2'd1;
         end
         // commit update
         if (state_ff == ST_OUT) begin
            pos_ff    <= t_ff[12];
            vel_ff    <= t_ff[13];
            cpp_ff    <= t_ff[15];
            cpv_ff    <= t_ff[11];
            cvp_ff    <= t_ff[8];
            cvv_ff    <= t_ff[9];
            out_ff    <= t_ff[12];
            ovalid_ff <= 1'b1;
         end
      end
      if (req_tvalid && req_tready && !req_tuser && !primed_ff) out_ff <= req_tdata[31:0];
      if (req_tvalid && req_tready) begin
         meas_ff <= req_tdata[31:0];
         dgap_ff <= gap[18:0];
      end else if (state_ff == ST_DT) begin
         // accumulate low, then high partial product; take the quotient
         if (dcnt_ff == 2'd2) begin
            dacc_ff <= 76'(dprod);
         end else if (dcnt_ff == 2'd1) begin
            dacc_ff <= dacc_ff + (76'(dprod) << 19);
         end else begin
            t_ff[0] <= 32'(dacc_ff >> DT_POST);
         end
      end
      if (wr_en) t_ff[wr_idx] <= alu_y;
      if (state_ff == ST_DIV && div_done) begin
         if (step_ff == 5'd15) t_ff[8] <= div_q;
         else t_ff[9] <= div_q;
      end
   end

   // output holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");
   // no input taken while busy
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_tready)
      else $error("ready while sequencer busy");
   // a result is raised only by a first update or the commit step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_OUT || $past(req_tvalid && req_tready))
      else $error("unexpected result word");

endmodule
